// ===== rtl/sdf_pkg.sv =====
// Shared types, constants and codes for the serial packet deframer.
// Used by every module under rtl and by the port checker; depends on nothing.
package sdf_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int HELD_W          = $clog2(MAX_FRAME_BYTES + 2);
    localparam int IDX_W           = 9;
    localparam int LEN_W           = 10;
    localparam int KIND_W          = 6;
    localparam int HDR_W           = 24;
    localparam int TICK_W          = 16;
    localparam int CMP_W           = (HELD_W > LEN_W + 1) ? HELD_W : LEN_W + 1;
    localparam int HDR_BYTES       = 3;

    localparam logic [7:0]        START_RESET   = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [KIND_W-1:0] DROP_RESET    = '0;
    localparam logic              DROP_EN_RESET = 1'b1;

    localparam logic [1:0] REG_START   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DROP    = 2'd2;
    localparam logic [1:0] REG_DROP_EN = 2'd3;

    localparam logic [2:0] ST_PARTIAL  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_FRAMING  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;
    localparam logic [2:0] ST_DROPPED  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        logic              drop_enable;
        logic [KIND_W-1:0] drop_kind;
        logic [TICK_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic       is_tick;
        logic       is_start;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        data;
        logic              bvalid;
        logic [IDX_W-1:0]  index;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic              last;
    } res_t;

endpackage

// ===== rtl/sdf_front.sv =====
// Front end: takes input transactions and classifies them as tick, start byte or data byte.
// Depends on sdf_pkg; feeds sdf_queue.
module sdf_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           start_marker,
    input  logic                 q_full,
    output logic                 push,
    output sdf_pkg::item_t       item
);

    assign in_stall      = q_full;
    assign push          = in_valid && !q_full;
    assign item.is_tick  = cmd;
    assign item.is_start = !cmd && (rx_byte == start_marker);
    assign item.data     = rx_byte;

endmodule

// ===== rtl/sdf_queue.sv =====
// Two-entry queue of classified items between the front end and the frame engine.
// Depends on sdf_pkg.
module sdf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sdf_pkg::item_t wr_item,
    input  logic           pop,
    output sdf_pkg::item_t rd_item,
    output logic           empty,
    output logic           full
);

    sdf_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/sdf_back.sv =====
// Frame engine: tracks phase, header, byte count and ticks, and registers one result.
// Depends on sdf_pkg; pops sdf_queue.
module sdf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sdf_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  sdf_pkg::item_t item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output sdf_pkg::res_t  res
);

    sdf_pkg::phase_t                 phase_reg, phase_next;
    logic [sdf_pkg::HELD_W-1:0]      held_reg, held_next;
    logic [sdf_pkg::HDR_W-1:0]       hdr_reg, hdr_next;
    logic [sdf_pkg::TICK_W-1:0]      ticks_reg, ticks_next;
    logic                            out_valid_reg, out_valid_next;
    sdf_pkg::res_t                   res_reg, res_next;

    logic                            adv;
    logic                            has_res;
    sdf_pkg::res_t                   res_new;
    logic [sdf_pkg::HDR_W-1:0]       hdr_cat;
    logic [sdf_pkg::HELD_W-1:0]      held_inc;
    logic [sdf_pkg::TICK_W-1:0]      ticks_inc;
    logic [sdf_pkg::CMP_W-1:0]       frame_end;

    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = !q_empty && adv;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign hdr_cat   = {hdr_reg[sdf_pkg::HDR_W-9:0], item.data};
    assign held_inc  = held_reg + 1'b1;
    assign ticks_inc = (ticks_reg != '1) ? ticks_reg + 1'b1 : ticks_reg;
    assign frame_end = sdf_pkg::CMP_W'(hdr_reg[sdf_pkg::LEN_W-1:0])
                       + sdf_pkg::CMP_W'(sdf_pkg::HDR_BYTES);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        hdr_next   = hdr_reg;
        ticks_next = ticks_reg;
        has_res    = 1'b0;
        res_new    = '0;
        if (pop)
        begin
            if (item.is_tick)
            begin
                if (phase_reg == sdf_pkg::PH_HEADER || phase_reg == sdf_pkg::PH_BODY)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > cfg.timeout_limit)
                    begin
                        has_res        = 1'b1;
                        res_new.status = sdf_pkg::ST_TIMEOUT;
                        res_new.last   = 1'b1;
                        if (phase_reg == sdf_pkg::PH_BODY)
                        begin
                            res_new.kind   = hdr_reg[sdf_pkg::HDR_W-1 -: sdf_pkg::KIND_W];
                            res_new.length = hdr_reg[sdf_pkg::LEN_W-1:0];
                        end
                        phase_next = sdf_pkg::PH_IDLE;
                        held_next  = '0;
                        hdr_next   = '0;
                        ticks_next = '0;
                    end
                end
            end
            else
            begin
                has_res = 1'b1;
                case (phase_reg)
                    sdf_pkg::PH_HEADER:
                    begin
                        hdr_next       = hdr_cat;
                        held_next      = held_inc;
                        res_new.data   = item.data;
                        res_new.bvalid = 1'b1;
                        res_new.index  = sdf_pkg::IDX_W'(held_reg);
                        res_new.status = sdf_pkg::ST_PARTIAL;
                        if (held_inc >= sdf_pkg::HELD_W'(sdf_pkg::HDR_BYTES))
                        begin
                            res_new.kind   = hdr_cat[sdf_pkg::HDR_W-1 -: sdf_pkg::KIND_W];
                            res_new.length = hdr_cat[sdf_pkg::LEN_W-1:0];
                            if (cfg.drop_enable
                                && hdr_cat[sdf_pkg::HDR_W-1 -: sdf_pkg::KIND_W] == cfg.drop_kind)
                            begin
                                res_new.status = sdf_pkg::ST_DROPPED;
                                res_new.last   = 1'b1;
                            end
                            else if (hdr_cat[sdf_pkg::LEN_W-1:0] == '0)
                            begin
                                res_new.status = sdf_pkg::ST_COMPLETE;
                                res_new.last   = 1'b1;
                            end
                            else
                            begin
                                phase_next = sdf_pkg::PH_BODY;
                            end
                            if (res_new.last)
                            begin
                                phase_next = sdf_pkg::PH_IDLE;
                                held_next  = '0;
                                hdr_next   = '0;
                                ticks_next = '0;
                            end
                        end
                    end
                    sdf_pkg::PH_BODY:
                    begin
                        res_new.kind   = hdr_reg[sdf_pkg::HDR_W-1 -: sdf_pkg::KIND_W];
                        res_new.length = hdr_reg[sdf_pkg::LEN_W-1:0];
                        if (held_reg > sdf_pkg::HELD_W'(sdf_pkg::MAX_FRAME_BYTES))
                        begin
                            res_new.status = sdf_pkg::ST_OVERSIZE;
                            res_new.last   = 1'b1;
                        end
                        else
                        begin
                            held_next      = held_inc;
                            res_new.data   = item.data;
                            res_new.bvalid = 1'b1;
                            res_new.index  = sdf_pkg::IDX_W'(held_reg);
                            if (sdf_pkg::CMP_W'(held_inc) == frame_end)
                            begin
                                res_new.status = sdf_pkg::ST_COMPLETE;
                                res_new.last   = 1'b1;
                            end
                            else
                            begin
                                res_new.status = sdf_pkg::ST_PARTIAL;
                            end
                        end
                        if (res_new.last)
                        begin
                            phase_next = sdf_pkg::PH_IDLE;
                            held_next  = '0;
                            hdr_next   = '0;
                            ticks_next = '0;
                        end
                    end
                    default:
                    begin
                        held_next  = '0;
                        hdr_next   = '0;
                        ticks_next = '0;
                        if (item.is_start)
                        begin
                            phase_next     = sdf_pkg::PH_HEADER;
                            res_new.status = sdf_pkg::ST_PARTIAL;
                        end
                        else
                        begin
                            phase_next     = sdf_pkg::PH_IDLE;
                            res_new.status = sdf_pkg::ST_FRAMING;
                        end
                    end
                endcase
            end
        end
        out_valid_next = adv ? (pop && has_res) : out_valid_reg;
        res_next       = (pop && has_res) ? res_new : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sdf_pkg::PH_IDLE;
            held_reg      <= '0;
            hdr_reg       <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            hdr_reg       <= hdr_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== rtl/serial_packet_deframer_core.sv =====
// Top level of the serial packet deframer: configuration registers, front end, queue, engine.
// Depends on sdf_pkg, sdf_front, sdf_queue and sdf_back.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_stall       cmd, rx_byte
//  out      output     out_valid / out_stall     status, out_byte, byte_valid, byte_index,
//                                                frame_kind, body_length, frame_last
//  cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transaction per cycle in both directions while in_stall and out_stall are low; a result
// passes through a queue entry register and then the single frame-engine result register.
// A two-entry queue sits between front end and engine; in_stall rises only when it is full.
// Ticks that cause no result leave the queue without occupying the output.
// rst_n clears phase, counters, queue and output valid, and loads register defaults.
module serial_packet_deframer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [7:0]                   out_byte,
    output logic                         byte_valid,
    output logic [sdf_pkg::IDX_W-1:0]    byte_index,
    output logic [sdf_pkg::KIND_W-1:0]   frame_kind,
    output logic [sdf_pkg::LEN_W-1:0]    body_length,
    output logic                         frame_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [sdf_pkg::TICK_W-1:0]   cfg_data
);

    logic [7:0]     start_marker_reg;
    sdf_pkg::cfg_t  cfg_reg;
    logic           q_full, q_empty, push, pop;
    sdf_pkg::item_t wr_item, rd_item;
    sdf_pkg::res_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg      <= sdf_pkg::START_RESET;
            cfg_reg.timeout_limit <= sdf_pkg::TIMEOUT_RESET;
            cfg_reg.drop_kind     <= sdf_pkg::DROP_RESET;
            cfg_reg.drop_enable   <= sdf_pkg::DROP_EN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sdf_pkg::REG_START:   start_marker_reg      <= cfg_data[7:0];
                sdf_pkg::REG_TIMEOUT: cfg_reg.timeout_limit <= cfg_data;
                sdf_pkg::REG_DROP:    cfg_reg.drop_kind     <= cfg_data[sdf_pkg::KIND_W-1:0];
                sdf_pkg::REG_DROP_EN: cfg_reg.drop_enable   <= cfg_data[0];
                default:              start_marker_reg      <= start_marker_reg;
            endcase
        end
    end

    sdf_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .start_marker (start_marker_reg),
        .q_full       (q_full),
        .push         (push),
        .item         (wr_item)
    );

    sdf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .empty   (q_empty),
        .full    (q_full)
    );

    sdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .item      (rd_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign status      = res.status;
    assign out_byte    = res.data;
    assign byte_valid  = res.bvalid;
    assign byte_index  = res.index;
    assign frame_kind  = res.kind;
    assign body_length = res.length;
    assign frame_last  = res.last;

endmodule

// ===== rtl/sdf_checker.sv =====
// Port-level checks on the deframer output channel, bound to the top level.
// Depends on sdf_pkg and serial_packet_deframer_core.
module sdf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [2:0]                   status,
    input logic [7:0]                   out_byte,
    input logic                         byte_valid,
    input logic [sdf_pkg::IDX_W-1:0]    byte_index,
    input logic [sdf_pkg::KIND_W-1:0]   frame_kind,
    input logic                         frame_last
);

    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_byte))
        else $error("output transaction changed while stalled");

    ast_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'd0 && byte_index == '0)
        else $error("byte fields nonzero without byte_valid");

    ast_framing_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sdf_pkg::ST_FRAMING |-> !frame_last && !byte_valid
        && frame_kind == '0)
        else $error("framing error result carries frame data");

    ast_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sdf_pkg::ST_COMPLETE || status == sdf_pkg::ST_TIMEOUT
        || status == sdf_pkg::ST_OVERSIZE || status == sdf_pkg::ST_DROPPED) |-> frame_last)
        else $error("closing result without frame_last");

endmodule

bind serial_packet_deframer_core sdf_checker u_sdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .byte_index (byte_index),
    .frame_kind (frame_kind),
    .frame_last (frame_last)
);
